[sv/qvt_pkg.sv]
`default_nettype none

package qvt_pkg;

    localparam int FRAC_BITS = 8;
    localparam int TRIG_BITS = 14;
    localparam int VW        = 18;
    localparam int SW        = 17 + FRAC_BITS;
    localparam logic [2:0] LAST_IDX = 3'd5;
    localparam logic [5:0] CORNER_U = 6'b011100;
    localparam logic [5:0] CORNER_V = 6'b110001;

    typedef logic signed [15:0]   trig_t;
    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [VW:0]   ext_t;
    typedef logic signed [VW+15:0] prod_t;
    typedef logic signed [VW+16:0] acc_t;
    typedef logic signed [SW-1:0] sprod_t;

    localparam trig_t SIN_TABLE [0:90] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    localparam acc_t TRIG_HALF = acc_t'(1) <<< (TRIG_BITS - 1);
    localparam ext_t POS_MAX   = ext_t'(32767);
    localparam ext_t POS_MIN   = -ext_t'(32768);

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic [8:0]         angle_x;
        logic [8:0]         angle_y;
        logic [8:0]         angle_z;
        logic [7:0]         texture_id;
    } req_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] idx;
        req_t       req;
    } issue_t;

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               tex_u;
        logic               tex_v;
        logic [7:0]         texture_id;
        logic               last;
    } side_t;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        side_t              side;
    } vout_t;

    function automatic logic [8:0] deg_wrap(logic [9:0] d);
        return (d >= 10'd360) ? 9'(d - 10'd360) : d[8:0];
    endfunction

    function automatic trig_t sin_deg(logic [8:0] a);
        logic [8:0] d;
        d = deg_wrap({1'b0, a});
        if (d <= 9'd90)
            return SIN_TABLE[d[6:0]];
        else if (d <= 9'd180)
            return SIN_TABLE[7'(9'd180 - d)];
        else if (d <= 9'd270)
            return -SIN_TABLE[7'(d - 9'd180)];
        else
            return -SIN_TABLE[7'(9'd360 - d)];
    endfunction

    function automatic trig_t cos_deg(logic [8:0] a);
        logic [8:0] d;
        d = deg_wrap({1'b0, a});
        return sin_deg(deg_wrap(10'(d) + 10'd90));
    endfunction

    function automatic vec_t scale_round(logic signed [15:0] s, logic pos);
        sprod_t h;
        sprod_t p;
        h = sprod_t'(1) <<< (FRAC_BITS - 1);
        p = sprod_t'(s) * h;
        if (!pos)
            p = -p;
        p = (p + h) >>> FRAC_BITS;
        return p[VW-1:0];
    endfunction

    function automatic vec_t round_trig(acc_t a);
        acc_t t;
        t = (a + TRIG_HALF) >>> TRIG_BITS;
        return t[VW-1:0];
    endfunction

    function automatic logic signed [15:0] sat16(ext_t v);
        if (v > POS_MAX)
            return 16'sh7fff;
        else if (v < POS_MIN)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

`default_nettype wire

[sv/qvt_seq.sv]
`default_nettype none

module qvt_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire qvt_pkg::req_t   req,
    output logic                 busy,
    output qvt_pkg::issue_t      issue
);

    qvt_pkg::req_t req_reg;
    logic          active_reg;
    logic          active_next;
    logic [2:0]    idx_reg;
    logic [2:0]    idx_next;
    logic          accept;

    assign busy   = active_reg && (idx_reg != qvt_pkg::LAST_IDX);
    assign accept = start && !busy;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (accept)
        begin
            active_next = 1'b1;
            idx_next    = 3'd0;
        end
        else if (active_reg)
        begin
            if (idx_reg == qvt_pkg::LAST_IDX)
                active_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 3'd0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
    end

    assign issue.valid = active_reg;
    assign issue.idx   = idx_reg;
    assign issue.req   = req_reg;

endmodule

`default_nettype wire

[sv/qvt_pipe.sv]
`default_nettype none

module qvt_pipe (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire qvt_pkg::issue_t  issue,
    output qvt_pkg::vout_t        vout
);

    logic [8:1] valid_reg;

    qvt_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg;
    qvt_pkg::side_t side5_reg, side6_reg, side7_reg, side8_reg;
    qvt_pkg::side_t side_next;

    qvt_pkg::vec_t  x0_reg, y0_reg;
    qvt_pkg::trig_t cz1_reg, sz1_reg;
    qvt_pkg::trig_t cy1_reg, sy1_reg, cy2_reg, sy2_reg, cy3_reg, sy3_reg;
    qvt_pkg::trig_t cx1_reg, sx1_reg, cx2_reg, sx2_reg, cx3_reg, sx3_reg;
    qvt_pkg::trig_t cx4_reg, sx4_reg, cx5_reg, sx5_reg;

    qvt_pkg::prod_t pa_reg, pb_reg, pc_reg, pd_reg;
    qvt_pkg::vec_t  x1_reg, y1_reg, y14_reg, y15_reg;
    qvt_pkg::prod_t qa_reg, qb_reg;
    qvt_pkg::vec_t  x2_reg, z2_reg, x26_reg, x27_reg;
    qvt_pkg::prod_t ra_reg, rb_reg, rc_reg, rd_reg;
    qvt_pkg::vec_t  y3_reg, z3_reg;

    logic signed [15:0] pos_x_reg, pos_y_reg, pos_z_reg;

    qvt_pkg::ext_t sum_x, sum_y;

    always_comb
    begin
        side_next.offset_x   = issue.req.offset_x;
        side_next.offset_y   = issue.req.offset_y;
        side_next.red        = issue.req.red;
        side_next.green      = issue.req.green;
        side_next.blue       = issue.req.blue;
        side_next.tex_u      = qvt_pkg::CORNER_U[issue.idx];
        side_next.tex_v      = qvt_pkg::CORNER_V[issue.idx];
        side_next.texture_id = issue.req.texture_id;
        side_next.last       = (issue.idx == qvt_pkg::LAST_IDX);
    end

    assign sum_x = qvt_pkg::ext_t'(x27_reg) + qvt_pkg::ext_t'(side7_reg.offset_x);
    assign sum_y = qvt_pkg::ext_t'(y3_reg) + qvt_pkg::ext_t'(side7_reg.offset_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[7:1], issue.valid};
    end

    always_ff @(posedge clk)
    begin
        // Corner scaling and angle lookup.
        side1_reg <= side_next;
        x0_reg    <= qvt_pkg::scale_round(issue.req.scale_x, side_next.tex_u);
        y0_reg    <= qvt_pkg::scale_round(issue.req.scale_y, side_next.tex_v);
        cz1_reg   <= qvt_pkg::cos_deg(issue.req.angle_z);
        sz1_reg   <= qvt_pkg::sin_deg(issue.req.angle_z);
        cy1_reg   <= qvt_pkg::cos_deg(issue.req.angle_y);
        sy1_reg   <= qvt_pkg::sin_deg(issue.req.angle_y);
        cx1_reg   <= qvt_pkg::cos_deg(issue.req.angle_x);
        sx1_reg   <= qvt_pkg::sin_deg(issue.req.angle_x);

        // Rotation about Z.
        side2_reg <= side1_reg;
        pa_reg    <= qvt_pkg::prod_t'(x0_reg) * qvt_pkg::prod_t'(cz1_reg);
        pb_reg    <= qvt_pkg::prod_t'(y0_reg) * qvt_pkg::prod_t'(sz1_reg);
        pc_reg    <= qvt_pkg::prod_t'(x0_reg) * qvt_pkg::prod_t'(sz1_reg);
        pd_reg    <= qvt_pkg::prod_t'(y0_reg) * qvt_pkg::prod_t'(cz1_reg);
        cy2_reg   <= cy1_reg;
        sy2_reg   <= sy1_reg;
        cx2_reg   <= cx1_reg;
        sx2_reg   <= sx1_reg;

        side3_reg <= side2_reg;
        x1_reg    <= qvt_pkg::round_trig(qvt_pkg::acc_t'(pa_reg) - qvt_pkg::acc_t'(pb_reg));
        y1_reg    <= qvt_pkg::round_trig(qvt_pkg::acc_t'(pc_reg) + qvt_pkg::acc_t'(pd_reg));
        cy3_reg   <= cy2_reg;
        sy3_reg   <= sy2_reg;
        cx3_reg   <= cx2_reg;
        sx3_reg   <= sx2_reg;

        // Rotation about Y; the incoming z is zero.
        side4_reg <= side3_reg;
        qa_reg    <= qvt_pkg::prod_t'(x1_reg) * qvt_pkg::prod_t'(cy3_reg);
        qb_reg    <= qvt_pkg::prod_t'(x1_reg) * qvt_pkg::prod_t'(sy3_reg);
        y14_reg   <= y1_reg;
        cx4_reg   <= cx3_reg;
        sx4_reg   <= sx3_reg;

        side5_reg <= side4_reg;
        x2_reg    <= qvt_pkg::round_trig(qvt_pkg::acc_t'(qa_reg));
        z2_reg    <= qvt_pkg::round_trig(-qvt_pkg::acc_t'(qb_reg));
        y15_reg   <= y14_reg;
        cx5_reg   <= cx4_reg;
        sx5_reg   <= sx4_reg;

        // Rotation about X.
        side6_reg <= side5_reg;
        ra_reg    <= qvt_pkg::prod_t'(y15_reg) * qvt_pkg::prod_t'(cx5_reg);
        rb_reg    <= qvt_pkg::prod_t'(z2_reg) * qvt_pkg::prod_t'(sx5_reg);
        rc_reg    <= qvt_pkg::prod_t'(y15_reg) * qvt_pkg::prod_t'(sx5_reg);
        rd_reg    <= qvt_pkg::prod_t'(z2_reg) * qvt_pkg::prod_t'(cx5_reg);
        x26_reg   <= x2_reg;

        side7_reg <= side6_reg;
        y3_reg    <= qvt_pkg::round_trig(qvt_pkg::acc_t'(ra_reg) - qvt_pkg::acc_t'(rb_reg));
        z3_reg    <= qvt_pkg::round_trig(qvt_pkg::acc_t'(rc_reg) + qvt_pkg::acc_t'(rd_reg));
        x27_reg   <= x26_reg;

        // Offset and saturation.
        side8_reg <= side7_reg;
        pos_x_reg <= qvt_pkg::sat16(sum_x);
        pos_y_reg <= qvt_pkg::sat16(sum_y);
        pos_z_reg <= qvt_pkg::sat16(qvt_pkg::ext_t'(z3_reg));
    end

    assign vout.valid = valid_reg[8];
    assign vout.pos_x = pos_x_reg;
    assign vout.pos_y = pos_y_reg;
    assign vout.pos_z = pos_z_reg;
    assign vout.side  = side8_reg;

endmodule

`default_nettype wire

[sv/quad_vertex_transform_top.sv]
`default_nettype none

// Channel    Handshake                  Payload
// request    start in, busy out         offsets, color, scales, angles, texture_in
// vertex     vertex_valid out (strobe)  pos_x/y/z, color, tex_u/v, texture_id, last_vertex
//
// A request is taken when start is high and busy is low; busy is low again in the cycle
// that issues the sixth corner, so a new request can be taken while the last corner of
// the one before is issued. One corner per cycle enters an eight-stage datapath, and that
// single vertex path sets the request rate. The first vertex reaches the ports through
// the sequencer's issue register and the datapath stages; the rest follow one per cycle.
// Reset clears the sequencer and the valid bits; the receiver cannot stall.

module quad_vertex_transform_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [15:0] offset_x,
    input  wire logic signed [15:0] offset_y,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic signed [15:0] scale_x,
    input  wire logic signed [15:0] scale_y,
    input  wire logic [8:0]  angle_x,
    input  wire logic [8:0]  angle_y,
    input  wire logic [8:0]  angle_z,
    input  wire logic signed [8:0] texture_in,
    output logic             vertex_valid,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic             tex_u,
    output logic             tex_v,
    output logic [7:0]       texture_id,
    output logic             last_vertex
);

    qvt_pkg::req_t   req;
    qvt_pkg::issue_t issue;
    qvt_pkg::vout_t  vout;
    logic [8:0]      tex_sum;

    // Untextured requests wrap to an id of zero.
    assign tex_sum = texture_in + 9'sd1;

    always_comb
    begin
        req.offset_x   = offset_x;
        req.offset_y   = offset_y;
        req.red        = red;
        req.green      = green;
        req.blue       = blue;
        req.scale_x    = scale_x;
        req.scale_y    = scale_y;
        req.angle_x    = angle_x;
        req.angle_y    = angle_y;
        req.angle_z    = angle_z;
        req.texture_id = tex_sum[7:0];
    end

    qvt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .issue (issue)
    );

    qvt_pipe u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .vout  (vout)
    );

    assign vertex_valid = vout.valid;
    assign pos_x        = vout.pos_x;
    assign pos_y        = vout.pos_y;
    assign pos_z        = vout.pos_z;
    assign out_red      = vout.side.red;
    assign out_green    = vout.side.green;
    assign out_blue     = vout.side.blue;
    assign tex_u        = vout.side.tex_u;
    assign tex_v        = vout.side.tex_v;
    assign texture_id   = vout.side.texture_id;
    assign last_vertex  = vout.side.last;

    a_accept_starts_quad: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (issue.valid && issue.idx == 3'd0))
        else $error("accepted request did not start at the first corner");

    a_ready_only_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && !busy) |-> (issue.idx == qvt_pkg::LAST_IDX))
        else $error("busy dropped before the last corner was issued");

    a_issue_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> ##8 vertex_valid)
        else $error("issued corner did not reach the vertex port");

    a_last_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && issue.idx == qvt_pkg::LAST_IDX) |-> ##8 last_vertex)
        else $error("last corner not marked on the vertex port");

endmodule

`default_nettype wire

[verif/quad_vertex_checker.sv]
module quad_vertex_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] offset_x,
    input  logic signed [15:0] offset_y,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic [8:0]         angle_x,
    input  logic [8:0]         angle_y,
    input  logic [8:0]         angle_z,
    input  logic signed [8:0]  texture_in,
    input  logic               vertex_valid,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic [7:0]         out_red,
    input  logic [7:0]         out_green,
    input  logic [7:0]         out_blue,
    input  logic               tex_u,
    input  logic               tex_v,
    input  logic [7:0]         texture_id,
    input  logic               last_vertex,
    output int                 vertices_due,
    output int                 mismatch_count
);

    localparam int POS_FRAC  = 8;
    localparam int SINE_FRAC = 14;

    // Corner order of the two triangles, first corner at index 0.
    localparam bit [0:5] U_SEQ = 6'b001110;
    localparam bit [0:5] V_SEQ = 6'b100011;

    localparam int QUARTER_SINE [0:90] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic               u;
        logic               v;
        logic [7:0]         tid;
        logic               last;
    } vertex_t;

    vertex_t pending_vertices [$];

    function automatic longint sine_deg(int unsigned deg);
        int unsigned d;
        d = deg % 360;
        if (d <= 90)
            return QUARTER_SINE[d];
        else if (d <= 180)
            return QUARTER_SINE[180 - d];
        else if (d <= 270)
            return -QUARTER_SINE[d - 180];
        else
            return -QUARTER_SINE[360 - d];
    endfunction

    function automatic longint cosine_deg(int unsigned deg);
        return sine_deg((deg % 360) + 90);
    endfunction

    // Adds one half and floors, so ties go toward plus infinity.
    function automatic longint round_off(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        else if (v < -32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic void transform_quad(
        input logic signed [15:0] ox,
        input logic signed [15:0] oy,
        input logic [7:0]         r,
        input logic [7:0]         g,
        input logic [7:0]         b,
        input logic signed [15:0] sx,
        input logic signed [15:0] sy,
        input logic [8:0]         ax,
        input logic [8:0]         ay,
        input logic [8:0]         az,
        input logic signed [8:0]  tex
    );
        longint cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
        longint half, cx, cy, x0, y0, x1, y1, x2, z2, y3, z3;
        logic [7:0] tid;
        vertex_t vtx;
        cos_x = cosine_deg(int'(ax));
        sin_x = sine_deg(int'(ax));
        cos_y = cosine_deg(int'(ay));
        sin_y = sine_deg(int'(ay));
        cos_z = cosine_deg(int'(az));
        sin_z = sine_deg(int'(az));
        half  = longint'(1) <<< (POS_FRAC - 1);
        tid   = (tex == -9'sd1) ? 8'd0 : 8'(longint'(tex) + 1);
        for (int k = 0; k < 6; k++)
        begin
            cx = U_SEQ[k] ? half : -half;
            cy = V_SEQ[k] ? half : -half;
            x0 = round_off(longint'(sx) * cx, POS_FRAC);
            y0 = round_off(longint'(sy) * cy, POS_FRAC);
            x1 = round_off(x0 * cos_z - y0 * sin_z, SINE_FRAC);
            y1 = round_off(x0 * sin_z + y0 * cos_z, SINE_FRAC);
            x2 = round_off(x1 * cos_y, SINE_FRAC);
            z2 = round_off(-x1 * sin_y, SINE_FRAC);
            y3 = round_off(y1 * cos_x - z2 * sin_x, SINE_FRAC);
            z3 = round_off(y1 * sin_x + z2 * cos_x, SINE_FRAC);
            vtx.px   = clamp16(x2 + longint'(ox));
            vtx.py   = clamp16(y3 + longint'(oy));
            vtx.pz   = clamp16(z3);
            vtx.r    = r;
            vtx.g    = g;
            vtx.b    = b;
            vtx.u    = U_SEQ[k];
            vtx.v    = V_SEQ[k];
            vtx.tid  = tid;
            vtx.last = (k == 5);
            pending_vertices = {pending_vertices, vtx};
        end
    endfunction

    always @(posedge clk)
    begin : watch
        vertex_t head;
        if (rst_n)
        begin
            if (vertex_valid)
            begin
                if (pending_vertices.size() == 0)
                begin
                    $error("vertex arrived with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    head = pending_vertices.pop_front();
                    if (pos_x !== head.px)
                    begin
                        $error("pos_x expected %0d got %0d", head.px, pos_x);
                        mismatch_count++;
                    end
                    if (pos_y !== head.py)
                    begin
                        $error("pos_y expected %0d got %0d", head.py, pos_y);
                        mismatch_count++;
                    end
                    if (pos_z !== head.pz)
                    begin
                        $error("pos_z expected %0d got %0d", head.pz, pos_z);
                        mismatch_count++;
                    end
                    if (out_red !== head.r)
                    begin
                        $error("out_red expected %0d got %0d", head.r, out_red);
                        mismatch_count++;
                    end
                    if (out_green !== head.g)
                    begin
                        $error("out_green expected %0d got %0d", head.g, out_green);
                        mismatch_count++;
                    end
                    if (out_blue !== head.b)
                    begin
                        $error("out_blue expected %0d got %0d", head.b, out_blue);
                        mismatch_count++;
                    end
                    if (tex_u !== head.u)
                    begin
                        $error("tex_u expected %0d got %0d", head.u, tex_u);
                        mismatch_count++;
                    end
                    if (tex_v !== head.v)
                    begin
                        $error("tex_v expected %0d got %0d", head.v, tex_v);
                        mismatch_count++;
                    end
                    if (texture_id !== head.tid)
                    begin
                        $error("texture_id expected %0d got %0d", head.tid, texture_id);
                        mismatch_count++;
                    end
                    if (last_vertex !== head.last)
                    begin
                        $error("last_vertex expected %0d got %0d", head.last, last_vertex);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                transform_quad(offset_x, offset_y, red, green, blue, scale_x, scale_y,
                               angle_x, angle_y, angle_z, texture_in);
        end
        vertices_due <= pending_vertices.size();
    end

endmodule

[verif/tb_quad_vertex_transform_top.sv]
module tb_quad_vertex_transform_top;

    typedef struct packed {
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [8:0]         ax;
        logic [8:0]         ay;
        logic [8:0]         az;
        logic signed [8:0]  tex;
    } quad_req_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [8:0]         angle_x;
    logic [8:0]         angle_y;
    logic [8:0]         angle_z;
    logic signed [8:0]  texture_in;
    logic               vertex_valid;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic               tex_u;
    logic               tex_v;
    logic [7:0]         texture_id;
    logic               last_vertex;
    int                 vertices_due;
    int                 mismatch_count;

    quad_vertex_transform_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .scale_x      (scale_x),
        .scale_y      (scale_y),
        .angle_x      (angle_x),
        .angle_y      (angle_y),
        .angle_z      (angle_z),
        .texture_in   (texture_in),
        .vertex_valid (vertex_valid),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .texture_id   (texture_id),
        .last_vertex  (last_vertex)
    );

    quad_vertex_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .offset_x       (offset_x),
        .offset_y       (offset_y),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .scale_x        (scale_x),
        .scale_y        (scale_y),
        .angle_x        (angle_x),
        .angle_y        (angle_y),
        .angle_z        (angle_z),
        .texture_in     (texture_in),
        .vertex_valid   (vertex_valid),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .texture_id     (texture_id),
        .last_vertex    (last_vertex),
        .vertices_due   (vertices_due),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic quad_req_t make_quad(
        input int ox, input int oy, input int r, input int g, input int b,
        input int sx, input int sy, input int ax, input int ay, input int az,
        input int tex
    );
        quad_req_t q;
        q.ox  = 16'(ox);
        q.oy  = 16'(oy);
        q.r   = 8'(r);
        q.g   = 8'(g);
        q.b   = 8'(b);
        q.sx  = 16'(sx);
        q.sy  = 16'(sy);
        q.ax  = 9'(ax);
        q.ay  = 9'(ay);
        q.az  = 9'(az);
        q.tex = 9'(tex);
        return q;
    endfunction

    // Most requests look like real sprites; the rest use random bit patterns.
    function automatic quad_req_t random_quad();
        quad_req_t q;
        if ($urandom_range(0, 9) < 6)
            q = make_quad($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255),
                          $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                          $urandom_range(0, 359), $urandom_range(0, 359),
                          $urandom_range(0, 359), $urandom_range(0, 255) - 1);
        else
            q = make_quad($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        return q;
    endfunction

    task automatic send_quad(input quad_req_t q);
        start      <= 1'b1;
        offset_x   <= q.ox;
        offset_y   <= q.oy;
        red        <= q.r;
        green      <= q.g;
        blue       <= q.b;
        scale_x    <= q.sx;
        scale_y    <= q.sy;
        angle_x    <= q.ax;
        angle_y    <= q.ay;
        angle_z    <= q.az;
        texture_in <= q.tex;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_vertices();
        start <= 1'b0;
        @(posedge clk);
        while (vertices_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        quad_req_t directed [18];
        rst_n      <= 1'b0;
        start      <= 1'b0;
        offset_x   <= '0;
        offset_y   <= '0;
        red        <= '0;
        green      <= '0;
        blue       <= '0;
        scale_x    <= '0;
        scale_y    <= '0;
        angle_x    <= '0;
        angle_y    <= '0;
        angle_z    <= '0;
        texture_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        directed[0]  = make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1);
        directed[1]  = make_quad(32767, 32767, 255, 255, 255, 32767, 32767, 0, 0, 0, 254);
        directed[2]  = make_quad(-32768, -32768, 0, 0, 0, -32768, -32768, 0, 0, 0, 0);
        directed[3]  = make_quad(100, -100, 1, 2, 3, 256, 256, 90, 90, 90, 255);
        directed[4]  = make_quad(0, 0, 10, 20, 30, 256, 512, 180, 180, 180, -256);
        directed[5]  = make_quad(-512, 512, 40, 50, 60, 384, -256, 270, 270, 270, -2);
        directed[6]  = make_quad(0, 0, 7, 8, 9, 1000, 1000, 359, 359, 359, 5);
        directed[7]  = make_quad(0, 0, 70, 80, 90, 1000, -1000, 360, 360, 360, 17);
        directed[8]  = make_quad(0, 0, 128, 64, 32, -1000, 1000, 511, 511, 511, 99);
        directed[9]  = make_quad(0, 0, 170, 85, 15, 1, -1, 45, 30, 60, 127);
        directed[10] = make_quad(0, 0, 85, 170, 240, 3, -3, 0, 0, 135, -1);
        directed[11] = make_quad(0, 0, 255, 0, 255, 32767, -32768, 45, 45, 45, 128);
        directed[12] = make_quad(32767, -32768, 0, 255, 0, 32767, 32767, 0, 0, 0, 200);
        directed[13] = make_quad(-32768, 32767, 1, 1, 1, -32768, -32768, 0, 180, 0, -100);
        directed[14] = make_quad(256, 256, 2, 4, 8, -1, 1, 89, 91, 269, 64);
        directed[15] = make_quad(-256, -256, 16, 32, 64, 255, 257, 300, 200, 100, 32);
        directed[16] = make_quad(0, 0, 99, 98, 97, 32767, 32767, 90, 0, 45, 1);
        directed[17] = make_quad(0, 0, 11, 22, 33, 32767, 32767, 0, 270, 45, 2);

        foreach (directed[i])
            send_quad(directed[i]);
        drain_vertices();

        for (int i = 0; i < 480; i++)
        begin
            send_quad(random_quad());
            if (i == 120 || i == 300)
                drain_vertices();
            else if (i < 420 && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 7));
        end

        drain_vertices();
        repeat (12) @(posedge clk);
        if (mismatch_count == 0 && vertices_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
